/* hdl/poi_pkg.sv */
// poi_pkg: shared constants, types and the cordic angle table for the
// planar odometry integrator; used by every module of the block
`default_nettype none

package poi_pkg;

   // cordic iterations, range 12 to 32
   localparam int CORDIC_STEPS  = 24;
   localparam int CORDIC_STEP_W = $clog2(CORDIC_STEPS);
   localparam int ATAN_IDX_W    = 5;

   // cordic datapath width, q2.30 with headroom
   localparam int CX_W = 34;
   localparam logic signed [CX_W-1:0] GAIN_Q30 = 34'sd652032874;
   localparam logic signed [CX_W-1:0] ONE_Q30  = 34'sd1073741824;

   // distance and heading scale factors, applied with a 2^-40 shift
   localparam logic [39:0] DIST_K = 40'd115292150;
   localparam logic [39:0] HEAD_K = 40'd75158796884;

   // position range
   localparam int POS_W = 40;
   localparam logic signed [POS_W-1:0] POS_MAX = 40'sh7F_FFFF_FFFF;
   localparam logic signed [POS_W-1:0] POS_MIN = 40'sh80_0000_0000;

   // multiply-accumulate unit
   localparam int ACC_W = 88;
   localparam logic [ACC_W-1:0] RND40 = ACC_W'(1) << 39;
   localparam logic [ACC_W-1:0] RND30 = ACC_W'(1) << 29;

   // partial product placement
   localparam logic [1:0] SH_0  = 2'd0;
   localparam logic [1:0] SH_24 = 2'd1;
   localparam logic [1:0] SH_32 = 2'd2;
   localparam logic [1:0] SH_56 = 2'd3;

   // accumulator start value on clear
   localparam logic [1:0] BIAS_NONE = 2'd0;
   localparam logic [1:0] BIAS_40   = 2'd1;
   localparam logic [1:0] BIAS_30   = 2'd2;

   typedef struct packed {
      logic        clear;
      logic [1:0]  bias;
      logic        mul;
      logic [31:0] opa;
      logic [31:0] opb;
      logic [1:0]  shift;
   } mac_cmd_type;

   // round(atan(2^-i) * 2^32 / (2*pi))
   function automatic logic [31:0] atan_entry(input logic [ATAN_IDX_W-1:0] idx);
      logic [31:0] v;
      case (idx)
         5'd0:    v = 32'h2000_0000;
         5'd1:    v = 32'h12E4_051E;
         5'd2:    v = 32'h09FB_385B;
         5'd3:    v = 32'h0511_11D4;
         5'd4:    v = 32'h028B_0D43;
         5'd5:    v = 32'h0145_D7E1;
         5'd6:    v = 32'h00A2_F61E;
         5'd7:    v = 32'h0051_7C55;
         5'd8:    v = 32'h0028_BE53;
         5'd9:    v = 32'h0014_5F2F;
         5'd10:   v = 32'h000A_2F98;
         5'd11:   v = 32'h0005_17CC;
         5'd12:   v = 32'h0002_8BE6;
         5'd13:   v = 32'h0001_45F3;
         5'd14:   v = 32'h0000_A2FA;
         5'd15:   v = 32'h0000_517D;
         5'd16:   v = 32'h0000_28BE;
         5'd17:   v = 32'h0000_145F;
         5'd18:   v = 32'h0000_0A30;
         5'd19:   v = 32'h0000_0518;
         5'd20:   v = 32'h0000_028C;
         5'd21:   v = 32'h0000_0146;
         5'd22:   v = 32'h0000_00A3;
         5'd23:   v = 32'h0000_0051;
         5'd24:   v = 32'h0000_0029;
         5'd25:   v = 32'h0000_0014;
         5'd26:   v = 32'h0000_000A;
         5'd27:   v = 32'h0000_0005;
         5'd28:   v = 32'h0000_0003;
         5'd29:   v = 32'h0000_0001;
         5'd30:   v = 32'h0000_0001;
         default: v = 32'h0000_0000;
      endcase
      return v;
   endfunction

endpackage

`default_nettype wire

/* hdl/poi_mac.sv */
// poi_mac: shared 32x32 multiplier with shifted accumulate
// depends on poi_pkg
`default_nettype none

module poi_mac (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire poi_pkg::mac_cmd_type      cmd,
   output logic [poi_pkg::ACC_W-1:0]      acc
);

   logic [63:0]               prod_ff, prod_in;
   logic [1:0]                sh_ff;
   logic                      pv_ff;
   logic [poi_pkg::ACC_W-1:0] acc_ff, acc_in;
   logic [poi_pkg::ACC_W-1:0] addend;
   logic [poi_pkg::ACC_W-1:0] bias_val;

   assign prod_in = 64'(cmd.opa) * 64'(cmd.opb);

   always_comb begin
      case (sh_ff)
         poi_pkg::SH_0:  addend = poi_pkg::ACC_W'(prod_ff);
         poi_pkg::SH_24: addend = poi_pkg::ACC_W'({prod_ff, 24'd0});
         poi_pkg::SH_32: addend = poi_pkg::ACC_W'({prod_ff, 32'd0});
         default:        addend = poi_pkg::ACC_W'({prod_ff, 56'd0});
      endcase
   end

   always_comb begin
      case (cmd.bias)
         poi_pkg::BIAS_40: bias_val = poi_pkg::RND40;
         poi_pkg::BIAS_30: bias_val = poi_pkg::RND30;
         default:          bias_val = '0;
      endcase
   end

   always_comb begin
      acc_in = acc_ff;
      if (cmd.clear) begin
         acc_in = bias_val;
      end else if (pv_ff) begin
         acc_in = acc_ff + addend;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pv_ff <= 1'b0;
      end else begin
         pv_ff <= cmd.mul;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      sh_ff   <= cmd.shift;
      acc_ff  <= acc_in;
   end

   assign acc = acc_ff;

endmodule

`default_nettype wire

/* hdl/poi_cordic.sv */
// poi_cordic: iterative rotation cordic, one micro-rotation per cycle
// depends on poi_pkg
`default_nettype none

module poi_cordic (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   input  wire logic [31:0]        angle,
   output logic                    busy,
   output logic signed [31:0]      cos_val,
   output logic signed [31:0]      sin_val
);

   localparam int CX_W   = poi_pkg::CX_W;
   localparam int STEP_W = poi_pkg::CORDIC_STEP_W;

   logic                     busy_ff, busy_in;
   logic [STEP_W-1:0]        cnt_ff, cnt_in;
   logic [1:0]               q_ff, q_in;
   logic signed [CX_W-1:0]   x_ff, x_in, y_ff, y_in;
   logic signed [31:0]       z_ff, z_in;
   logic [31:0]              rot;
   logic [31:0]              resid;
   logic signed [CX_W-1:0]   xs, ys;
   logic signed [31:0]       step_ang;
   logic signed [CX_W-1:0]   xc, yc;
   logic signed [31:0]       xn, yn, ca, sa;

   // quadrant split, residual in [-2^29, 2^29)
   assign rot   = angle + 32'h2000_0000;
   assign resid = angle - {rot[31:30], 30'd0};

   assign xs       = x_ff >>> cnt_ff;
   assign ys       = y_ff >>> cnt_ff;
   assign step_ang = $signed(poi_pkg::atan_entry(poi_pkg::ATAN_IDX_W'(cnt_ff)));

   always_comb begin
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      q_in    = q_ff;
      x_in    = x_ff;
      y_in    = y_ff;
      z_in    = z_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         q_in    = rot[31:30];
         x_in    = poi_pkg::GAIN_Q30;
         y_in    = '0;
         z_in    = $signed(resid);
      end else if (busy_ff) begin
         if (!z_ff[31]) begin
            x_in = x_ff - ys;
            y_in = y_ff + xs;
            z_in = z_ff - step_ang;
         end else begin
            x_in = x_ff + ys;
            y_in = y_ff - xs;
            z_in = z_ff + step_ang;
         end
         if (cnt_ff == STEP_W'(poi_pkg::CORDIC_STEPS - 1)) begin
            busy_in = 1'b0;
         end else begin
            cnt_in = cnt_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff <= cnt_in;
      q_ff   <= q_in;
      x_ff   <= x_in;
      y_ff   <= y_in;
      z_ff   <= z_in;
   end

   // clamp to unit magnitude
   always_comb begin
      xc = x_ff;
      yc = y_ff;
      if (x_ff > poi_pkg::ONE_Q30)  xc = poi_pkg::ONE_Q30;
      if (x_ff < -poi_pkg::ONE_Q30) xc = -poi_pkg::ONE_Q30;
      if (y_ff > poi_pkg::ONE_Q30)  yc = poi_pkg::ONE_Q30;
      if (y_ff < -poi_pkg::ONE_Q30) yc = -poi_pkg::ONE_Q30;
      xn = 32'(xc);
      yn = 32'(yc);
   end

   // odd quadrant swaps, upper half negates
   always_comb begin
      if (q_ff[0]) begin
         ca = -yn;
         sa = xn;
      end else begin
         ca = xn;
         sa = yn;
      end
      if (q_ff[1]) begin
         cos_val = -ca;
         sin_val = -sa;
      end else begin
         cos_val = ca;
         sin_val = sa;
      end
   end

   assign busy = busy_ff;

endmodule

`default_nettype wire

/* hdl/planar_odometry_integrator_top.sv */
// planar_odometry_integrator_top: dead-reckoning pose integrator, sequencer
// around a shared multiply-accumulate unit and an iterative cordic
// depends on poi_pkg, poi_mac, poi_cordic
//
// usage
//   req channel: one speed report per item (linear and angular speed, 32-bit
//   microsecond stamp). an item is taken when req_valid is high and req_stall
//   is low. req_stall stays high while an item is being worked on.
//   rsp channel: pose (x, y, heading) plus echoed speeds, taken when rsp_valid
//   is high and rsp_stall is low.
//   the first item after reset only records its stamp: no rsp item follows.
//   every later item gives exactly one rsp item.
// result timing
//   a primed item shows on rsp in the same cycle that req_stall drops, once the
//   output register is free; a new item is taken only after the last is handed
//   over. from 18 cordic steps up the cordic iterations decide when a result is
//   ready; the dt, distance and heading multiplies run alongside them.
// reset
//   synchronous, active high: pose, heading and stamp clear to zero, the
//   block returns to unprimed and the rsp register empties.
// stall
//   the result sits in an output register; a stalled rsp holds its item and
//   the block still takes the next req item. a second finished result waits
//   in the sequencer until the output register frees.
`default_nettype none

module planar_odometry_integrator_top (
   input  wire logic               clock,
   input  wire logic               reset,

   input  wire logic               req_valid,
   output logic                    req_stall,
   input  wire logic signed [15:0] req_linear_speed,
   input  wire logic signed [15:0] req_angular_speed,
   input  wire logic [31:0]        req_time_stamp,

   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   output logic signed [39:0]      rsp_pos_x,
   output logic signed [39:0]      rsp_pos_y,
   output logic [31:0]             rsp_heading,
   output logic signed [15:0]      rsp_linear_velocity,
   output logic signed [15:0]      rsp_angular_velocity
);

   localparam int POS_W = poi_pkg::POS_W;
   localparam int ACC_W = poi_pkg::ACC_W;

   // sequencer phases
   localparam logic [3:0] ST_IDLE = 4'd0;
   localparam logic [3:0] ST_LIN  = 4'd1;  // |linear| * dt
   localparam logic [3:0] ST_ANG  = 4'd2;  // |angular| * dt
   localparam logic [3:0] ST_DIST = 4'd3;  // distance scaling, 4 partials
   localparam logic [3:0] ST_HEAD = 4'd4;  // heading step scaling, 4 partials
   localparam logic [3:0] ST_DX   = 4'd5;  // distance * cos
   localparam logic [3:0] ST_DY   = 4'd6;  // distance * sin
   localparam logic [3:0] ST_POS  = 4'd7;  // saturating add, heading update
   localparam logic [3:0] ST_OUT  = 4'd8;  // hand over to output register

   logic [3:0]              state_ff, state_in;
   logic [2:0]              cnt_ff, cnt_in;
   logic [2:0]              npp;

   // block state
   logic                    primed_ff, primed_in;
   logic [31:0]             last_ff, last_in;
   logic [31:0]             yaw_ff, yaw_in;
   logic signed [POS_W-1:0] pos_x_ff, pos_x_in, pos_y_ff, pos_y_in;

   // per-item working registers
   logic signed [15:0]      lin_ff, lin_in, ang_ff, ang_in;
   logic [31:0]             dt_ff, dt_in;
   logic [47:0]             plin_ff, plin_in, pang_ff, pang_in;
   logic [33:0]             dmag_ff, dmag_in;
   logic [31:0]             hstep_ff, hstep_in;
   logic signed [34:0]      dx_ff, dx_in, dy_ff, dy_in;

   // output register
   logic                    rsp_valid_ff, rsp_valid_in;
   logic signed [POS_W-1:0] rsp_x_ff, rsp_x_in, rsp_y_ff, rsp_y_in;
   logic [31:0]             rsp_h_ff, rsp_h_in;
   logic signed [15:0]      rsp_lin_ff, rsp_lin_in, rsp_ang_ff, rsp_ang_in;

   logic                    req_take;
   logic                    issue, capture, hold;
   logic [15:0]             lin_mag, ang_mag;
   logic [31:0]             cos_mag, sin_mag, trig_mag;
   logic [47:0]             p_sel;
   logic [39:0]             k_sel;
   logic [33:0]             r_val;
   logic                    r_neg;
   logic signed [POS_W:0]   sum_x, sum_y;

   poi_pkg::mac_cmd_type    mac_cmd;
   logic [ACC_W-1:0]        acc;
   logic                    cordic_busy;
   logic signed [31:0]      cos_val, sin_val;

   poi_mac u_mac (
      .clock (clock),
      .reset (reset),
      .cmd   (mac_cmd),
      .acc   (acc)
   );

   poi_cordic u_cordic (
      .clock   (clock),
      .reset   (reset),
      .start   (req_take && primed_ff),
      .angle   (yaw_ff),
      .busy    (cordic_busy),
      .cos_val (cos_val),
      .sin_val (sin_val)
   );

   assign req_stall = (state_ff != ST_IDLE);
   assign req_take  = req_valid && !req_stall;

   // operand magnitudes
   assign lin_mag = lin_ff[15] ? (16'd0 - $unsigned(lin_ff)) : $unsigned(lin_ff);
   assign ang_mag = ang_ff[15] ? (16'd0 - $unsigned(ang_ff)) : $unsigned(ang_ff);
   assign cos_mag = cos_val[31] ? (32'd0 - $unsigned(cos_val)) : $unsigned(cos_val);
   assign sin_mag = sin_val[31] ? (32'd0 - $unsigned(sin_val)) : $unsigned(sin_val);
   assign trig_mag = (state_ff == ST_DX) ? cos_mag : sin_mag;

   assign p_sel = (state_ff == ST_DIST) ? plin_ff : pang_ff;
   assign k_sel = (state_ff == ST_DIST) ? poi_pkg::DIST_K : poi_pkg::HEAD_K;

   // partial products per phase
   always_comb begin
      case (state_ff)
         ST_LIN, ST_ANG:   npp = 3'd1;
         ST_DIST, ST_HEAD: npp = 3'd4;
         ST_DX, ST_DY:     npp = 3'd2;
         default:          npp = 3'd0;
      endcase
   end

   // cos and sin are needed from the first distance * cos product on
   assign hold    = (state_ff == ST_DX) && cordic_busy;
   assign issue   = (cnt_ff < npp) && !hold;
   assign capture = (npp != 3'd0) && (cnt_ff == npp + 3'd1);

   // rounded scaled distance from the accumulator, sign applied
   assign r_val = acc[63:30];
   assign r_neg = lin_ff[15] ^ ((state_ff == ST_DX) ? cos_val[31] : sin_val[31]);

   assign sum_x = {pos_x_ff[POS_W-1], pos_x_ff} + (POS_W+1)'(dx_ff);
   assign sum_y = {pos_y_ff[POS_W-1], pos_y_ff} + (POS_W+1)'(dy_ff);

   // micro-op issue to the shared multiplier
   always_comb begin
      mac_cmd = '0;
      if (issue) begin
         mac_cmd.mul   = 1'b1;
         mac_cmd.clear = (cnt_ff == 3'd0);
         case (state_ff)
            ST_LIN: begin
               mac_cmd.opa = 32'(lin_mag);
               mac_cmd.opb = dt_ff;
            end
            ST_ANG: begin
               mac_cmd.opa = 32'(ang_mag);
               mac_cmd.opb = dt_ff;
            end
            ST_DIST, ST_HEAD: begin
               mac_cmd.bias = poi_pkg::BIAS_40;
               case (cnt_ff)
                  3'd0: begin
                     mac_cmd.opa   = 32'(p_sel[23:0]);
                     mac_cmd.opb   = k_sel[31:0];
                     mac_cmd.shift = poi_pkg::SH_0;
                  end
                  3'd1: begin
                     mac_cmd.opa   = 32'(p_sel[47:24]);
                     mac_cmd.opb   = k_sel[31:0];
                     mac_cmd.shift = poi_pkg::SH_24;
                  end
                  3'd2: begin
                     mac_cmd.opa   = 32'(p_sel[23:0]);
                     mac_cmd.opb   = 32'(k_sel[39:32]);
                     mac_cmd.shift = poi_pkg::SH_32;
                  end
                  default: begin
                     mac_cmd.opa   = 32'(p_sel[47:24]);
                     mac_cmd.opb   = 32'(k_sel[39:32]);
                     mac_cmd.shift = poi_pkg::SH_56;
                  end
               endcase
            end
            default: begin
               mac_cmd.bias = poi_pkg::BIAS_30;
               mac_cmd.opb  = trig_mag;
               if (cnt_ff == 3'd0) begin
                  mac_cmd.opa   = 32'(dmag_ff[23:0]);
                  mac_cmd.shift = poi_pkg::SH_0;
               end else begin
                  mac_cmd.opa   = 32'(dmag_ff[33:24]);
                  mac_cmd.shift = poi_pkg::SH_24;
               end
            end
         endcase
      end
   end

   // sequencer and datapath registers
   always_comb begin
      state_in   = state_ff;
      cnt_in     = cnt_ff;
      primed_in  = primed_ff;
      last_in    = last_ff;
      yaw_in     = yaw_ff;
      pos_x_in   = pos_x_ff;
      pos_y_in   = pos_y_ff;
      lin_in     = lin_ff;
      ang_in     = ang_ff;
      dt_in      = dt_ff;
      plin_in    = plin_ff;
      pang_in    = pang_ff;
      dmag_in    = dmag_ff;
      hstep_in   = hstep_ff;
      dx_in      = dx_ff;
      dy_in      = dy_ff;
      rsp_x_in   = rsp_x_ff;
      rsp_y_in   = rsp_y_ff;
      rsp_h_in   = rsp_h_ff;
      rsp_lin_in = rsp_lin_ff;
      rsp_ang_in = rsp_ang_ff;

      rsp_valid_in = rsp_valid_ff && rsp_stall;

      case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               last_in = req_time_stamp;
               if (!primed_ff) begin
                  // first report only primes the stamp
                  primed_in = 1'b1;
               end else begin
                  dt_in    = req_time_stamp - last_ff;
                  lin_in   = req_linear_speed;
                  ang_in   = req_angular_speed;
                  state_in = ST_LIN;
                  cnt_in   = '0;
               end
            end
         end
         ST_LIN, ST_ANG, ST_DIST, ST_HEAD, ST_DX, ST_DY: begin
            if (capture) begin
               cnt_in = '0;
               case (state_ff)
                  ST_LIN: begin
                     plin_in  = acc[47:0];
                     state_in = ST_ANG;
                  end
                  ST_ANG: begin
                     pang_in  = acc[47:0];
                     state_in = ST_DIST;
                  end
                  ST_DIST: begin
                     dmag_in  = acc[73:40];
                     state_in = ST_HEAD;
                  end
                  ST_HEAD: begin
                     hstep_in = acc[71:40];
                     state_in = ST_DX;
                  end
                  ST_DX: begin
                     dx_in    = r_neg ? -$signed(35'(r_val)) : $signed(35'(r_val));
                     state_in = ST_DY;
                  end
                  default: begin
                     dy_in    = r_neg ? -$signed(35'(r_val)) : $signed(35'(r_val));
                     state_in = ST_POS;
                  end
               endcase
            end else if (!hold) begin
               cnt_in = cnt_ff + 3'd1;
            end
         end
         ST_POS: begin
            // saturate on overflow into the guard bit
            if (sum_x[POS_W] != sum_x[POS_W-1]) begin
               pos_x_in = sum_x[POS_W] ? poi_pkg::POS_MIN : poi_pkg::POS_MAX;
            end else begin
               pos_x_in = sum_x[POS_W-1:0];
            end
            if (sum_y[POS_W] != sum_y[POS_W-1]) begin
               pos_y_in = sum_y[POS_W] ? poi_pkg::POS_MIN : poi_pkg::POS_MAX;
            end else begin
               pos_y_in = sum_y[POS_W-1:0];
            end
            // heading wraps, stepped after position uses the old heading
            yaw_in   = ang_ff[15] ? (yaw_ff - hstep_ff) : (yaw_ff + hstep_ff);
            state_in = ST_OUT;
         end
         ST_OUT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_x_in     = pos_x_ff;
               rsp_y_in     = pos_y_ff;
               rsp_h_in     = yaw_ff;
               rsp_lin_in   = lin_ff;
               rsp_ang_in   = ang_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         primed_ff    <= 1'b0;
         last_ff      <= '0;
         yaw_ff       <= '0;
         pos_x_ff     <= '0;
         pos_y_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         primed_ff    <= primed_in;
         last_ff      <= last_in;
         yaw_ff       <= yaw_in;
         pos_x_ff     <= pos_x_in;
         pos_y_ff     <= pos_y_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      lin_ff     <= lin_in;
      ang_ff     <= ang_in;
      dt_ff      <= dt_in;
      plin_ff    <= plin_in;
      pang_ff    <= pang_in;
      dmag_ff    <= dmag_in;
      hstep_ff   <= hstep_in;
      dx_ff      <= dx_in;
      dy_ff      <= dy_in;
      rsp_x_ff   <= rsp_x_in;
      rsp_y_ff   <= rsp_y_in;
      rsp_h_ff   <= rsp_h_in;
      rsp_lin_ff <= rsp_lin_in;
      rsp_ang_ff <= rsp_ang_in;
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_pos_x            = rsp_x_ff;
   assign rsp_pos_y            = rsp_y_ff;
   assign rsp_heading          = rsp_h_ff;
   assign rsp_linear_velocity  = rsp_lin_ff;
   assign rsp_angular_velocity = rsp_ang_ff;

   // priming item leaves the sequencer idle
   a_prime_only: assert property (@(posedge clock) disable iff (reset)
      (req_take && !primed_ff) |=> (state_ff == ST_IDLE && primed_ff))
      else $error("priming item started the sequencer");

   // a primed item starts both the multiplier sequence and the cordic
   a_item_start: assert property (@(posedge clock) disable iff (reset)
      (req_take && primed_ff) |=> (state_ff == ST_LIN && cnt_ff == 3'd0 && cordic_busy))
      else $error("item did not start the sequence");

   // distance products only use a settled cos
   a_trig_ready: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DX && mac_cmd.mul) |-> !cordic_busy)
      else $error("cos used while cordic still iterating");

   // a new result only comes from the hand-over phase
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(state_ff) == ST_OUT))
      else $error("result raised outside hand-over");

endmodule

`default_nettype wire

/* sim/testbench.sv */
// testbench for planar_odometry_integrator_top: drives speed reports and checks every pose
// against a bit-exact dead-reckoning predictor kept inside the bench
// depends on hdl/poi_pkg.sv and hdl/planar_odometry_integrator_top.sv
`timescale 1ns / 100ps

module testbench;

   // primed item to result, cordic steps plus sequencing
   localparam int RESULT_LATENCY = poi_pkg::CORDIC_STEPS + 11;
   localparam int ANGLE_STEPS    = poi_pkg::CORDIC_STEPS;
   localparam int RANDOM_REPORTS = 640;

   // distance scale round(2^60 / 1e10), heading scale round(2^72 / (2*pi*1e10))
   localparam logic [63:0] DIST_SCALE = 64'd115292150;
   localparam logic [63:0] HEAD_SCALE = 64'd75158796884;
   localparam longint GAIN_Q30 = 64'sd652032874;
   localparam longint ONE_Q30  = 64'sd1073741824;
   localparam longint POS_HI   = 64'sd549755813887;
   localparam longint POS_LO   = -64'sd549755813888;

   localparam logic signed [15:0] SPEED_MAX = 16'sh7FFF;
   localparam logic signed [15:0] SPEED_MIN = 16'sh8000;

   typedef struct {
      logic signed [39:0] pos_x;
      logic signed [39:0] pos_y;
      logic [31:0]        heading;
      logic signed [15:0] linear_velocity;
      logic signed [15:0] angular_velocity;
   } pose_report_type;

   logic               clock;
   logic               reset;
   logic               req_valid;
   logic               req_stall;
   logic signed [15:0] req_linear_speed;
   logic signed [15:0] req_angular_speed;
   logic [31:0]        req_time_stamp;
   logic               rsp_valid;
   logic               rsp_stall;
   logic signed [39:0] rsp_pos_x;
   logic signed [39:0] rsp_pos_y;
   logic [31:0]        rsp_heading;
   logic signed [15:0] rsp_linear_velocity;
   logic signed [15:0] rsp_angular_velocity;

   // predictor state: pose, last stamp and whether the first report has been seen
   longint      odo_x = 0;
   longint      odo_y = 0;
   logic [31:0] odo_yaw = '0;
   logic [31:0] odo_last = '0;
   bit          odo_primed = 1'b0;

   pose_report_type pending_poses[$];
   int              mismatch_count = 0;
   bit              no_idle = 1'b0;

   // round(atan(2^-i) * 2^32 / (2*pi))
   logic [31:0] arctan_lut [0:31] = '{
      32'h2000_0000, 32'h12E4_051E, 32'h09FB_385B, 32'h0511_11D4,
      32'h028B_0D43, 32'h0145_D7E1, 32'h00A2_F61E, 32'h0051_7C55,
      32'h0028_BE53, 32'h0014_5F2F, 32'h000A_2F98, 32'h0005_17CC,
      32'h0002_8BE6, 32'h0001_45F3, 32'h0000_A2FA, 32'h0000_517D,
      32'h0000_28BE, 32'h0000_145F, 32'h0000_0A30, 32'h0000_0518,
      32'h0000_028C, 32'h0000_0146, 32'h0000_00A3, 32'h0000_0051,
      32'h0000_0029, 32'h0000_0014, 32'h0000_000A, 32'h0000_0005,
      32'h0000_0003, 32'h0000_0001, 32'h0000_0001, 32'h0000_0000
   };

   planar_odometry_integrator_top i_dut (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_stall            (req_stall),
      .req_linear_speed     (req_linear_speed),
      .req_angular_speed    (req_angular_speed),
      .req_time_stamp       (req_time_stamp),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_pos_x            (rsp_pos_x),
      .rsp_pos_y            (rsp_pos_y),
      .rsp_heading          (rsp_heading),
      .rsp_linear_velocity  (rsp_linear_velocity),
      .rsp_angular_velocity (rsp_angular_velocity)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // ------------------------------------------------------------------
   // predictor
   // ------------------------------------------------------------------

   // round(mag * k / 2^40), halves up, magnitudes only
   function automatic logic [63:0] mul_round40(input logic [63:0] mag, input logic [63:0] k);
      logic [127:0] prod;
      prod = 128'(mag) * 128'(k) + (128'd1 << 39);
      return prod[103:40];
   endfunction

   // round(travel * ratio / 2^30), sign applied to the rounded magnitude
   function automatic longint scale_q30(input longint travel, input longint ratio);
      logic [127:0] prod;
      longint       md;
      longint       mt;
      md = (travel < 0) ? -travel : travel;
      mt = (ratio < 0) ? -ratio : ratio;
      prod = 128'(md) * 128'(mt) + (128'd1 << 29);
      prod = prod >> 30;
      return ((travel < 0) != (ratio < 0)) ? -longint'(prod[63:0]) : longint'(prod[63:0]);
   endfunction

   function automatic longint clamp_add(input longint pos, input longint delta);
      longint r;
      r = pos + delta;
      if (r > POS_HI) r = POS_HI;
      if (r < POS_LO) r = POS_LO;
      return r;
   endfunction

   // rotation-mode cordic on the residual angle, quadrant folded back in afterwards
   function automatic void cordic_sin_cos(input logic [31:0] angle,
                                          output longint cos_q30, output longint sin_q30);
      logic [1:0]  quad;
      logic [31:0] resid;
      longint      z;
      longint      vx;
      longint      vy;
      longint      tx;
      quad  = 2'((angle + 32'h2000_0000) >> 30);
      resid = angle - {quad, 30'd0};
      z     = longint'($signed(resid));
      vx    = GAIN_Q30;
      vy    = 0;
      for (int i = 0; i < ANGLE_STEPS; i++) begin
         tx = vx;
         if (z >= 0) begin
            vx = vx - (vy >>> i);
            vy = vy + (tx >>> i);
            z  = z - longint'(arctan_lut[i]);
         end else begin
            vx = vx + (vy >>> i);
            vy = vy - (tx >>> i);
            z  = z + longint'(arctan_lut[i]);
         end
      end
      if (vx > ONE_Q30) vx = ONE_Q30;
      if (vx < -ONE_Q30) vx = -ONE_Q30;
      if (vy > ONE_Q30) vy = ONE_Q30;
      if (vy < -ONE_Q30) vy = -ONE_Q30;
      case (quad)
         2'd0: begin cos_q30 = vx;  sin_q30 = vy;  end
         2'd1: begin cos_q30 = -vy; sin_q30 = vx;  end
         2'd2: begin cos_q30 = -vx; sin_q30 = -vy; end
         default: begin cos_q30 = vy; sin_q30 = -vx; end
      endcase
   endfunction

   // advance the pose by one accepted report and queue the pose it should produce
   function automatic void integrate_report(input logic signed [15:0] lin,
                                            input logic signed [15:0] ang,
                                            input logic [31:0] stamp);
      longint          lin_w;
      longint          ang_w;
      longint          travel;
      longint          cos_q;
      longint          sin_q;
      logic [31:0]     dt;
      logic [63:0]     mag;
      logic [63:0]     yaw_step;
      pose_report_type expected_pose;
      if (!odo_primed) begin
         // first report only primes the stamp
         odo_last   = stamp;
         odo_primed = 1'b1;
         return;
      end
      dt       = stamp - odo_last;
      odo_last = stamp;
      lin_w    = lin;
      ang_w    = ang;

      mag    = 64'((lin_w < 0) ? -lin_w : lin_w) * 64'(dt);
      travel = longint'(mul_round40(mag, DIST_SCALE));
      if (lin_w < 0) travel = -travel;

      // position moves along the heading held before this report
      cordic_sin_cos(odo_yaw, cos_q, sin_q);
      odo_x = clamp_add(odo_x, scale_q30(travel, cos_q));
      odo_y = clamp_add(odo_y, scale_q30(travel, sin_q));

      mag      = 64'((ang_w < 0) ? -ang_w : ang_w) * 64'(dt);
      yaw_step = mul_round40(mag, HEAD_SCALE);
      odo_yaw  = (ang_w < 0) ? odo_yaw - yaw_step[31:0] : odo_yaw + yaw_step[31:0];

      expected_pose.pos_x            = odo_x[39:0];
      expected_pose.pos_y            = odo_y[39:0];
      expected_pose.heading          = odo_yaw;
      expected_pose.linear_velocity  = lin;
      expected_pose.angular_velocity = ang;
      pending_poses.push_back(expected_pose);
   endfunction

   // ------------------------------------------------------------------
   // stimulus helpers
   // ------------------------------------------------------------------

   function automatic int pick_idle();
      return no_idle ? 0 : $urandom_range(0, 6);
   endfunction

   // extremes and zero often, small speeds sometimes, otherwise any value
   function automatic logic signed [15:0] pick_speed();
      case ($urandom_range(0, 9))
         0: return SPEED_MIN;
         1: return SPEED_MAX;
         2: return 16'sd0;
         3, 4: return 16'($signed($urandom_range(0, 400)) - 200);
         default: return 16'($urandom);
      endcase
   endfunction

   // dt that turns the predicted heading onto target at full yaw rate
   function automatic logic [31:0] turn_dt(input logic [31:0] target, input bit clockwise);
      logic [31:0]  step;
      logic [127:0] num;
      step = clockwise ? odo_yaw - target : target - odo_yaw;
      num  = (128'(step) << 40) / (128'(HEAD_SCALE) * (clockwise ? 128'd32768 : 128'd32767));
      return num[31:0];
   endfunction

   // called at a falling edge, returns at the falling edge after the item is taken
   task automatic send_report(input logic signed [15:0] lin, input logic signed [15:0] ang,
                              input logic [31:0] stamp);
      int gap;
      gap = pick_idle();
      if (gap > 0) begin
         req_valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid         = 1'b1;
      req_linear_speed  = lin;
      req_angular_speed = ang;
      req_time_stamp    = stamp;
      do @(posedge clock); while (req_stall !== 1'b0);
      integrate_report(lin, ang, stamp);
      @(negedge clock);
   endtask

   task automatic turn_to(input logic [31:0] target, input bit clockwise,
                          input logic signed [15:0] lin);
      send_report(lin, clockwise ? SPEED_MIN : SPEED_MAX, odo_last + turn_dt(target, clockwise));
   endtask

   // hold the sender off until every queued pose has come back
   task automatic wait_for_drain();
      req_valid = 1'b0;
      while (pending_poses.size() != 0) @(posedge clock);
      @(negedge clock);
   endtask

   // ------------------------------------------------------------------
   // tests
   // ------------------------------------------------------------------

   // first report after reset records its stamp and must not give a result
   task automatic test_priming();
      send_report(16'sd1234, -16'sd77, 32'hFFFF_FF00);
   endtask

   // stamp wrap, repeated stamp, backwards stamp and the speed extremes
   task automatic test_stamp_wrap();
      send_report(SPEED_MAX, SPEED_MAX, 32'h0000_0010);   // wraps, heading still zero
      send_report(SPEED_MIN, SPEED_MIN, 32'h0000_0010);   // repeat, dt zero
      send_report(16'sd0, SPEED_MAX, 32'h0000_000F);      // backwards, dt near 2^32
      send_report(SPEED_MIN, SPEED_MIN, 32'hFFFF_FFFF);
      send_report(SPEED_MAX, 16'sd0, 32'h0000_0000);      // dt of one
      send_report(-16'sd1, 16'sd1, 32'h0000_0000);
   endtask

   // walk the heading through every octant both ways and move in each
   task automatic test_heading_quadrants();
      for (int k = 0; k < 8; k++) begin
         turn_to(32'(k) << 29, k[0], pick_speed());
         send_report(pick_speed(), 16'sd0, odo_last + $urandom_range(1000, 400000));
      end
   endtask

   // drive both axes into the upper and then the lower saturation limit
   task automatic test_saturation();
      turn_to(32'h2000_0000, 1'b0, 16'sd0);
      while (odo_x != POS_HI || odo_y != POS_HI)
         send_report(SPEED_MAX, 16'sd0, odo_last - 32'd1);
      repeat (3) send_report(SPEED_MAX, 16'sd0, odo_last - 32'd1);
      while (odo_x != POS_LO || odo_y != POS_LO)
         send_report(SPEED_MIN, 16'sd0, odo_last - 32'd1);
      repeat (3) send_report(SPEED_MIN, 16'sd0, odo_last - 32'd1);
   endtask

   // random reports, mostly realistic few-ms intervals with some odd stamps
   task automatic test_random_reports();
      logic [31:0] dt;
      for (int n = 0; n < RANDOM_REPORTS; n++) begin
         // a stretch with no idling on either side every 160 items
         no_idle = (n % 160) >= 120;
         if (n == RANDOM_REPORTS / 2) wait_for_drain();
         case ($urandom_range(0, 19))
            0: dt = 32'd0;
            1: dt = $urandom;
            2: dt = 32'hFFFF_FFFF - $urandom_range(0, 1000);
            3, 4: dt = $urandom_range(0, 1 << 20);
            default: dt = $urandom_range(1, 20000);
         endcase
         send_report(pick_speed(), pick_speed(), odo_last + dt);
      end
      no_idle = 1'b0;
   endtask

   // ------------------------------------------------------------------
   // result side: random stall per item, field-by-field compare
   // ------------------------------------------------------------------
   initial begin
      pose_report_type want;
      int              stall_left;
      stall_left = 0;
      rsp_stall  = 1'b0;
      forever begin
         @(posedge clock);
         if (reset) begin
            stall_left = 0;
         end else if (rsp_valid === 1'b1) begin
            if (rsp_stall) begin
               if (stall_left > 0) stall_left--;
            end else begin
               if (pending_poses.size() == 0) begin
                  $error("unexpected pose item: x %0d y %0d heading %0h",
                         rsp_pos_x, rsp_pos_y, rsp_heading);
                  mismatch_count++;
               end else begin
                  want = pending_poses.pop_front();
                  if (rsp_pos_x !== want.pos_x) begin
                     $error("pos_x: expected %0d, actual %0d", want.pos_x, rsp_pos_x);
                     mismatch_count++;
                  end
                  if (rsp_pos_y !== want.pos_y) begin
                     $error("pos_y: expected %0d, actual %0d", want.pos_y, rsp_pos_y);
                     mismatch_count++;
                  end
                  if (rsp_heading !== want.heading) begin
                     $error("heading: expected %0h, actual %0h", want.heading, rsp_heading);
                     mismatch_count++;
                  end
                  if (rsp_linear_velocity !== want.linear_velocity) begin
                     $error("linear_velocity: expected %0d, actual %0d",
                            want.linear_velocity, rsp_linear_velocity);
                     mismatch_count++;
                  end
                  if (rsp_angular_velocity !== want.angular_velocity) begin
                     $error("angular_velocity: expected %0d, actual %0d",
                            want.angular_velocity, rsp_angular_velocity);
                     mismatch_count++;
                  end
               end
               stall_left = pick_idle();
            end
         end
         @(negedge clock);
         rsp_stall = (stall_left > 0);
      end
   end

   // ------------------------------------------------------------------
   // main sequence
   // ------------------------------------------------------------------
   initial begin
      reset             = 1'b1;
      req_valid         = 1'b0;
      req_linear_speed  = '0;
      req_angular_speed = '0;
      req_time_stamp    = '0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_priming();
      test_stamp_wrap();
      test_heading_quadrants();
      test_saturation();
      test_random_reports();

      // let everything drain, then a quiet spell to catch stray items
      req_valid = 1'b0;
      while (pending_poses.size() != 0) @(posedge clock);
      repeat (2 * RESULT_LATENCY) @(posedge clock);
      if (mismatch_count == 0 && pending_poses.size() == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

   // watchdog, far beyond the slowest legal run
   initial begin
      #2_000_000;
      $display("TEST FAILED");
      $finish;
   end

endmodule

/* planar_odometry_integrator_top.f */
hdl/poi_pkg.sv
hdl/poi_mac.sv
hdl/poi_cordic.sv
hdl/planar_odometry_integrator_top.sv
sim/testbench.sv
